// File: rtl/core/mxt_pkg.sv
// ----------------------------------------------------------------------------
// mxt_pkg
// Shared types for the max-xor subarray trie: datapath opcodes, controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package mxt_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_CLEAR,
    DP_Q_LOAD,
    DP_Q_WALK,
    DP_I_LOAD,
    DP_I_WALK,
    DP_I_ALLOC,
    DP_OUT_LOAD
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_Q_LOAD,
    ST_Q_WALK,
    ST_I_LOAD,
    ST_I_WALK,
    ST_I_ALLOC,
    ST_OUT
  } mxt_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   seed;
  } dp_ctl_t;

  typedef struct packed {
    logic q_done;
    logic i_done;
    logic i_alloc;
    logic out_busy;
  } dp_sts_t;

endpackage

// File: rtl/core/max_xor_subarray_trie.sv
// An accepted word runs the query walk and then the insert walk before its result is
// loaded; when first_item is set, the trie is first cleared and reseeded.
// A new word is taken only once the last has reached the result register; the single
// read port walks one level a cycle for the query and again for the insert, bar the
// step that writes a missing link. Reset: the trie is cleared and seeded with prefix
// zero with in_ready low; in_ready rises while a finished word still waits at the output.
// ----------------------------------------------------------------------------
// max_xor_subarray_trie
// Maximum subarray xor over a word stream, using a binary trie of prefix xors.
// ----------------------------------------------------------------------------
module max_xor_subarray_trie import mxt_pkg::*; #(
  parameter int KEY_BITS  = 32,
  parameter int MAX_ITEMS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_item_value,
  input  logic              in_first_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_best_xor,
  output logic              out_capacity_overflow
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  mxt_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_first_item (in_first_item),
    .in_ready      (in_ready),
    .ctl           (ctl),
    .sts           (sts)
  );

  mxt_dp #(
    .KEY_BITS  (KEY_BITS),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctl                   (ctl),
    .sts                   (sts),
    .in_item_value         (in_item_value),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_best_xor          (out_best_xor),
    .out_capacity_overflow (out_capacity_overflow)
  );

endmodule

// File: rtl/core/mxt_dp.sv
// ----------------------------------------------------------------------------
// mxt_dp
// Datapath: prefix and best registers, trie node memory with one registered
// read port, walk registers for query and insert, and the result register.
// ----------------------------------------------------------------------------
module mxt_dp import mxt_pkg::*; #(
  parameter int KEY_BITS  = 32,
  parameter int MAX_ITEMS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_ctl_t           ctl,
  output dp_sts_t           sts,
  input  logic [DATA_W-1:0] in_item_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_best_xor,
  output logic              out_capacity_overflow
);

  localparam int NODE_CAP = MAX_ITEMS * KEY_BITS + 1;
  localparam int AW       = $clog2(NODE_CAP);
  localparam int NU_W     = $clog2(NODE_CAP + 1);
  localparam int CW       = NU_W + 1;
  localparam int LW       = $clog2(KEY_BITS);

  logic [AW-1:0]       mem0_r [NODE_CAP];
  logic [AW-1:0]       mem1_r [NODE_CAP];
  logic [AW-1:0]       rd0_r, rd1_r;

  logic [KEY_BITS-1:0] item_r, prefix_r, best_r, acc_r;
  logic [AW-1:0]       node_r;
  logic [LW-1:0]       lvl_r;
  logic [NU_W-1:0]     nodes_used_r;
  logic                ovf_r;
  logic                out_valid_r, out_ovf_r;
  logic [DATA_W-1:0]   out_best_r;

  logic [KEY_BITS-1:0] key, acc_fin;
  logic [LW-1:0]       lvl_dn;
  logic                bit_k, bit_dn, want;
  logic [AW-1:0]       link_w, link_o, q_nxt, link_i;
  logic                q_hit, q_dead, i_miss, fits;
  logic [CW-1:0]       need_end;
  logic [AW-1:0]       rd_addr, wa, wd0, wd1;
  logic                we0, we1;

  assign key    = ctl.seed ? '0 : prefix_r;
  assign lvl_dn = lvl_r - LW'(1);
  assign bit_k  = key[lvl_r];
  assign bit_dn = key[lvl_dn];

  // query: prefer the opposite branch at each level
  assign want    = ~prefix_r[lvl_r];
  assign link_w  = want ? rd1_r : rd0_r;
  assign link_o  = want ? rd0_r : rd1_r;
  assign q_hit   = (link_w != '0);
  assign q_dead  = !q_hit && (link_o == '0);
  assign q_nxt   = q_hit ? link_w : link_o;
  assign acc_fin = acc_r | (q_hit ? (KEY_BITS'(1) << lvl_r) : '0);

  // insert: a missing link at level L needs L+1 fresh nodes
  assign link_i   = bit_k ? rd1_r : rd0_r;
  assign i_miss   = (link_i == '0);
  assign need_end = CW'(nodes_used_r) + CW'(lvl_r) + CW'(1);
  assign fits     = (need_end <= CW'(NODE_CAP));

  always_comb begin
    rd_addr = node_r;
    wa      = node_r;
    we0     = 1'b0;
    we1     = 1'b0;
    wd0     = '0;
    wd1     = '0;
    case (ctl.op)
      DP_CLEAR: begin
        wa  = '0;
        we0 = 1'b1;
        we1 = 1'b1;
      end
      DP_Q_LOAD, DP_I_LOAD: begin
        rd_addr = '0;
      end
      DP_Q_WALK: begin
        rd_addr = q_nxt;
      end
      DP_I_WALK: begin
        rd_addr = link_i;
        if (i_miss && fits) begin
          we0 = !bit_k;
          we1 = bit_k;
          wd0 = AW'(nodes_used_r);
          wd1 = AW'(nodes_used_r);
        end
      end
      DP_I_ALLOC: begin
        we0 = 1'b1;
        we1 = 1'b1;
        if (lvl_r != '0) begin
          wd0 = bit_dn ? '0 : AW'(nodes_used_r);
          wd1 = bit_dn ? AW'(nodes_used_r) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we0) mem0_r[wa] <= wd0;
    if (we1) mem1_r[wa] <= wd1;
    rd0_r <= mem0_r[rd_addr];
    rd1_r <= mem1_r[rd_addr];
  end

  always_comb begin
    sts.q_done   = (ctl.op == DP_Q_WALK) && ((lvl_r == '0) || q_dead);
    sts.i_done   = ((ctl.op == DP_I_WALK) && ((!i_miss && (lvl_r == '0)) || (i_miss && !fits)))
                || ((ctl.op == DP_I_ALLOC) && (lvl_r == '0));
    sts.i_alloc  = (ctl.op == DP_I_WALK) && i_miss && fits;
    sts.out_busy = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      DP_ACCEPT: begin
        item_r <= in_item_value[KEY_BITS-1:0];
      end
      DP_CLEAR: begin
        prefix_r <= '0;
        best_r   <= '0;
      end
      DP_Q_LOAD: begin
        prefix_r <= prefix_r ^ item_r;
        node_r   <= '0;
        lvl_r    <= LW'(KEY_BITS - 1);
        acc_r    <= '0;
      end
      DP_Q_WALK: begin
        acc_r  <= acc_fin;
        node_r <= q_nxt;
        lvl_r  <= lvl_dn;
        if (sts.q_done && (acc_fin > best_r)) begin
          best_r <= acc_fin;
        end
      end
      DP_I_LOAD: begin
        node_r <= '0;
        lvl_r  <= LW'(KEY_BITS - 1);
      end
      DP_I_WALK: begin
        ovf_r <= i_miss && !fits;
        if (!i_miss) begin
          node_r <= link_i;
          lvl_r  <= lvl_dn;
        end else if (fits) begin
          node_r <= AW'(nodes_used_r);
        end
      end
      DP_I_ALLOC: begin
        node_r <= AW'(nodes_used_r);
        lvl_r  <= lvl_dn;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_used_r <= NU_W'(1);
    end else if (ctl.op == DP_CLEAR) begin
      nodes_used_r <= NU_W'(1);
    end else if (sts.i_alloc || ((ctl.op == DP_I_ALLOC) && (lvl_r != '0))) begin
      nodes_used_r <= nodes_used_r + NU_W'(1);
    end
  end

  // result register, frees the walk while a word waits downstream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.op == DP_OUT_LOAD) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == DP_OUT_LOAD) begin
      out_best_r <= DATA_W'(best_r);
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_best_xor          = out_best_r;
  assign out_capacity_overflow = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_nodes_cap: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r <= NODE_CAP)
    else $error("node count beyond capacity");

  a_best_mono: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && (ctl.op != DP_CLEAR) |=> best_r >= $past(best_r))
    else $error("best xor decreased within a sequence");

  a_alloc_root: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == DP_I_ALLOC) |-> (wa != '0))
    else $error("allocation overwrote the root node");
`endif

endmodule

// File: rtl/core/mxt_ctrl.sv
// ----------------------------------------------------------------------------
// mxt_ctrl
// Controller: sequences trie clear and seeding, the query walk, the insert
// walk with node allocation, and the hand-off to the result register.
// ----------------------------------------------------------------------------
module mxt_ctrl import mxt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_first_item,
  output logic    in_ready,
  output dp_ctl_t ctl,
  input  dp_sts_t sts
);

  mxt_state_t state_r, state_nxt;
  logic       seed_r, seed_nxt;
  logic       pend_r, pend_nxt;
  logic       ins_end;

  assign ins_end = ((state_r == ST_I_WALK) || (state_r == ST_I_ALLOC)) && sts.i_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      seed_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seed_r  <= seed_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    seed_nxt  = seed_r;
    pend_nxt  = pend_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_first_item) begin
            state_nxt = ST_CLEAR;
            pend_nxt  = 1'b1;
          end else begin
            state_nxt = ST_Q_LOAD;
          end
        end
      end
      ST_CLEAR: begin
        state_nxt = ST_I_LOAD;
        seed_nxt  = 1'b1;
      end
      ST_Q_LOAD: state_nxt = ST_Q_WALK;
      ST_Q_WALK: begin
        if (sts.q_done) state_nxt = ST_I_LOAD;
      end
      ST_I_LOAD: state_nxt = ST_I_WALK;
      ST_I_WALK, ST_I_ALLOC: begin
        if (ins_end) begin
          // seeding the zero prefix ends without a result word
          if (seed_r) begin
            seed_nxt  = 1'b0;
            pend_nxt  = 1'b0;
            state_nxt = pend_r ? ST_Q_LOAD : ST_IDLE;
          end else begin
            state_nxt = ST_OUT;
          end
        end else if (sts.i_alloc) begin
          state_nxt = ST_I_ALLOC;
        end
      end
      ST_OUT: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl.seed = seed_r;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.op   = in_valid ? DP_ACCEPT : DP_NOP;
      end
      ST_CLEAR:   ctl.op = DP_CLEAR;
      ST_Q_LOAD:  ctl.op = DP_Q_LOAD;
      ST_Q_WALK:  ctl.op = DP_Q_WALK;
      ST_I_LOAD:  ctl.op = DP_I_LOAD;
      ST_I_WALK:  ctl.op = DP_I_WALK;
      ST_I_ALLOC: ctl.op = DP_I_ALLOC;
      ST_OUT:     ctl.op = sts.out_busy ? DP_NOP : DP_OUT_LOAD;
      default:    ctl.op = DP_NOP;
    endcase
  end

endmodule
